// ===== rtl/core/lapt_pkg.sv =====
// Shared constants, beat type and CRC helpers for the lap transponder packet builder.
`timescale 1ns / 1ps
package lapt_pkg;

  localparam int unsigned IdWidth     = 32;
  localparam int unsigned PacketWidth = 48;
  localparam int unsigned BcdWidth    = 32;
  localparam int unsigned CrcWidth    = 16;

  // IDs at or above this saturate to all nines, but for the forced lead nibble
  localparam logic [IdWidth-1:0] BCD_LIMIT = 32'd100000000;
  // below the limit an ID fits in this many bits
  localparam int unsigned ValWidth = 27;

  localparam logic [7:0]  LEAD_NIBBLE = 8'hF0;
  localparam logic [7:0]  SAT_BYTE    = 8'h99;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  // floor(x / 10000) = (x * DIV10K_MUL) >> DIV10K_SHIFT for x < 2^27
  localparam logic [27:0]  DIV10K_MUL   = 28'd219902326;
  localparam int unsigned  DIV10K_SHIFT = 41;
  localparam logic [13:0]  TEN_THOUSAND = 14'd10000;
  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x < 10000
  localparam logic [12:0]  DIV100_MUL   = 13'd5243;
  localparam int unsigned  DIV100_SHIFT = 19;
  localparam logic [6:0]   HUNDRED      = 7'd100;
  // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT for x < 100
  localparam logic [7:0]   DIV10_MUL    = 8'd205;
  localparam int unsigned  DIV10_SHIFT  = 11;
  localparam logic [3:0]   TEN          = 4'd10;

  // accept edge to the edge that samples the result strobe
  localparam int unsigned Latency = 8;

  // four packed BCD bytes {B3, B2, B1, B0} handed from the digit pipe to the CRC stage
  typedef struct packed {
    logic                vld;
    logic [BcdWidth-1:0] bytes;
  } bcd_beat_t;

  typedef logic [BcdWidth-1:0][CrcWidth-1:0] crc_cols_t;

  // bit-serial CRC over B0, B1, B2, B3, each MSB first, initial value zero
  function automatic logic [CrcWidth-1:0] crc_serial(logic [BcdWidth-1:0] w);
    logic [CrcWidth-1:0] c;
    c = '0;
    for (int i = 0; i < 4; i++) begin
      c = c ^ {w[8*i +: 8], 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[CrcWidth-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
    end
    return c;
  endfunction

  // the CRC is linear with zero seed: one column per input bit
  function automatic crc_cols_t crc_columns();
    crc_cols_t cols;
    for (int j = 0; j < BcdWidth; j++) begin
      cols[j] = crc_serial(32'd1 << j);
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_columns();

endpackage

// ===== rtl/core/lapt_bcd_conv.sv =====
// Pipelined binary to eight-digit BCD conversion with saturation and forced lead nibble.
`timescale 1ns / 1ps
module lapt_bcd_conv
  import lapt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [IdWidth-1:0] id_i,
  output bcd_beat_t          beat_o
);

  // stage 0: capture
  logic                s0_vld_q, s0_sat_q;
  logic [ValWidth-1:0] s0_x_q;
  // stage 1: quotient by ten thousand
  logic                s1_vld_q, s1_sat_q;
  logic [ValWidth-1:0] s1_x_q;
  logic [13:0]         s1_hi_q;
  // stage 2: two four-digit halves, [1] upper, [0] lower
  logic                s2_vld_q, s2_sat_q;
  logic [1:0][13:0]    s2_half_q;
  // stage 3: halves with their quotient by a hundred
  logic                s3_vld_q, s3_sat_q;
  logic [1:0][13:0]    s3_half_q;
  logic [1:0][6:0]     s3_h_q;
  // stage 4: four two-digit pairs, [3] most significant
  logic                s4_vld_q, s4_sat_q;
  logic [3:0][6:0]     s4_pair_q;
  // stage 5: pairs with their tens digit
  logic                s5_vld_q, s5_sat_q;
  logic [3:0][6:0]     s5_pair_q;
  logic [3:0][3:0]     s5_tens_q;
  // stage 6: output beat
  logic                s6_vld_q;
  logic [BcdWidth-1:0] s6_bytes_q;

  logic [54:0]         prod1;
  logic [ValWidth-1:0] hi_scaled;
  logic [1:0][13:0]    half_d;
  logic [1:0][26:0]    prod3;
  logic [1:0][6:0]     h_d;
  logic [3:0][6:0]     pair_d;
  logic [3:0][14:0]    prod5;
  logic [3:0][3:0]     tens_d;
  logic [BcdWidth-1:0] bytes_d;

  assign prod1     = 55'(s0_x_q) * 55'(DIV10K_MUL);
  assign hi_scaled = ValWidth'(s1_hi_q) * ValWidth'(TEN_THOUSAND);
  assign half_d[1] = s1_hi_q;
  assign half_d[0] = 14'(s1_x_q - hi_scaled);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod3[i] = 27'(s2_half_q[i]) * 27'(DIV100_MUL);
      h_d[i]   = prod3[i][DIV100_SHIFT +: 7];
    end
    for (int i = 0; i < 2; i++) begin
      pair_d[2*i+1] = s3_h_q[i];
      pair_d[2*i]   = 7'(s3_half_q[i] - 14'(s3_h_q[i]) * 14'(HUNDRED));
    end
    for (int i = 0; i < 4; i++) begin
      prod5[i]  = 15'(s4_pair_q[i]) * 15'(DIV10_MUL);
      tens_d[i] = prod5[i][DIV10_SHIFT +: 4];
    end
    for (int i = 0; i < 4; i++) begin
      bytes_d[8*i +: 8] = s5_sat_q ? SAT_BYTE
                        : {s5_tens_q[i], 4'(s5_pair_q[i] - 7'(s5_tens_q[i]) * 7'(TEN))};
    end
    // overwrite the leading digit with the fixed nibble
    bytes_d[31:24] = bytes_d[31:24] | LEAD_NIBBLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= vld_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_sat_q   <= (id_i >= BCD_LIMIT);
    s0_x_q     <= id_i[ValWidth-1:0];
    s1_sat_q   <= s0_sat_q;
    s1_x_q     <= s0_x_q;
    s1_hi_q    <= prod1[DIV10K_SHIFT +: 14];
    s2_sat_q   <= s1_sat_q;
    s2_half_q  <= half_d;
    s3_sat_q   <= s2_sat_q;
    s3_half_q  <= s2_half_q;
    s3_h_q     <= h_d;
    s4_sat_q   <= s3_sat_q;
    s4_pair_q  <= pair_d;
    s5_sat_q   <= s4_sat_q;
    s5_pair_q  <= s4_pair_q;
    s5_tens_q  <= tens_d;
    s6_bytes_q <= bytes_d;
  end

  assign beat_o.vld   = s6_vld_q;
  assign beat_o.bytes = s6_bytes_q;

endmodule

// ===== rtl/core/lapt_crc_pack.sv =====
// CRC-16 over the BCD bytes, packet assembly, inversion and result register.
`timescale 1ns / 1ps
module lapt_crc_pack
  import lapt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bcd_beat_t              beat_i,
  output logic                   vld_o,
  output logic [PacketWidth-1:0] packet_o
);

  logic                   vld_q;
  logic [PacketWidth-1:0] packet_q, packet_d;
  logic [CrcWidth-1:0]    crc;

  // sum the precomputed column of every set data bit
  always_comb begin
    crc = '0;
    for (int j = 0; j < BcdWidth; j++) begin
      if (beat_i.bytes[j]) begin
        crc = crc ^ CRC_COLS[j];
      end
    end
    packet_d = ~{beat_i.bytes[31:24], crc[15:8], beat_i.bytes[23:0], crc[7:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    packet_q <= packet_d;
  end

  assign vld_o    = vld_q;
  assign packet_o = packet_q;

endmodule

// ===== rtl/core/lap_transponder_packet_builder.sv =====
// The packet for an ID taken at one edge passes stages s0 to s6 and the CRC result register before it is strobed.
// Throughput: one ID per cycle; busy stays low, the eight-register pipe never stalls.
// The depth is set by the chain of reciprocal multiplies that splits the ID into digits.
// The receiver cannot stall: each packet is shown for one cycle with packet_valid_o.
// Reset clears the valid bits of every stage; no packet is in flight after reset.
`timescale 1ns / 1ps
module lap_transponder_packet_builder
  import lapt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [IdWidth-1:0]     transponder_id_i,
  output logic [PacketWidth-1:0] packet_o,
  output logic                   packet_valid_o
);

  bcd_beat_t bcd_beat;

  assign busy = 1'b0;

  lapt_bcd_conv u_bcd_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start & ~busy),
    .id_i   (transponder_id_i),
    .beat_o (bcd_beat)
  );

  lapt_crc_pack u_crc_pack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (bcd_beat),
    .vld_o    (packet_valid_o),
    .packet_o (packet_o)
  );

endmodule

// ===== rtl/core/lapt_checker.sv =====
// Port-level checks on the packet builder, bound to the top level.
`timescale 1ns / 1ps
module lapt_checker
  import lapt_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic [IdWidth-1:0]     transponder_id_i,
  input logic [PacketWidth-1:0] packet_o,
  input logic                   packet_valid_o
);

  // every accepted beat gives a packet after the fixed latency
  a_beat_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency packet_valid_o)
    else $error("accepted beat gave no packet");

  // no packet without an accepted beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    packet_valid_o |-> $past(start && !busy, Latency))
    else $error("packet without accepted beat");

  // the inverted lead nibble is always zero
  a_lead_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    packet_valid_o |-> (packet_o[47:44] == 4'h0))
    else $error("lead nibble not forced");

  // oversized IDs give nines in every digit but the forced lead nibble
  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (packet_valid_o && ($past(transponder_id_i, Latency) >= BCD_LIMIT))
      |-> ((packet_o[47:40] == 8'h06) && (packet_o[31:8] == 24'h666666)))
    else $error("saturated ID not all nines");

endmodule

bind lap_transponder_packet_builder lapt_checker u_lapt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .transponder_id_i (transponder_id_i),
  .packet_o         (packet_o),
  .packet_valid_o   (packet_valid_o)
);
